// ===== hdl/fpsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fill pattern span classifier.
// Holds the beat structs, the register map and the reset values; no dependencies.
package fpsc_pkg;

    localparam int OUT_COUNT_BITS     = 24;
    localparam int DEF_COUNT_BITS     = 24;
    localparam int APB_ADDR_BITS      = 3;
    localparam int APB_DATA_BITS      = 32;

    // Register index, taken from paddr[2] (word-aligned register map).
    localparam logic REG_FILL_BYTE       = 1'b0;
    localparam logic REG_MAX_BROKEN_RUNS = 1'b1;

    localparam logic [7:0] FILL_BYTE_RESET       = 8'd0;
    localparam logic [7:0] MAX_BROKEN_RUNS_RESET = 8'd10;

    typedef logic [OUT_COUNT_BITS-1:0] out_count_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_beat_t;

    typedef struct packed {
        logic       likely_flooded;
        logic       fully_flooded;
        out_count_t fill_count;
        out_count_t fill_run_count;
        out_count_t broken_run_count;
    } out_beat_t;

endpackage

// ===== hdl/fill_pattern_span_classifier_core.sv =====
`timescale 1ns / 1ps
// Fill pattern span classifier: counts fill bytes, fill runs and broken runs per region.
// Depends on fpsc_pkg for the beat structs and register map.

// One byte is taken per clock cycle whenever the result register is empty or being
// drained, and a region's verdict appears in the result register on the cycle after
// the final byte is accepted. The per-region counters are updated directly from the
// input beat; the result register on the output side is the only stage, and a stalled
// result holds off further input. Counters saturate at 2^COUNT_BITS - 1 and are
// reported in 24 bits. Registers are at byte offsets 0 (fill byte) and 4 (broken run
// limit) and should only be written while no region is in progress.
module fill_pattern_span_classifier_core #(
    parameter int COUNT_BITS = fpsc_pkg::DEF_COUNT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fpsc_pkg::in_beat_t                  s_payload,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output fpsc_pkg::out_beat_t                 m_payload,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpsc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [fpsc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [fpsc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import fpsc_pkg::*;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == '1) ? v : v + cnt_t'(1);
    endfunction

    logic [7:0] fill_byte_reg;
    logic [7:0] max_broken_runs_reg;

    cnt_t byte_total_reg,    byte_total_next;
    cnt_t matched_total_reg, matched_total_next;
    cnt_t run_total_reg,     run_total_next;
    cnt_t break_total_reg,   break_total_next;
    logic inside_run_reg,    inside_run_next;
    logic seen_other_reg,    seen_other_next;

    logic      m_valid_reg, m_valid_next;
    out_beat_t result_reg,  result_next;

    logic s_fire;
    logic hit;
    logic cfg_wr;
    logic likely;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_MAX_BROKEN_RUNS)
                   ? {{(APB_DATA_BITS-8){1'b0}}, max_broken_runs_reg}
                   : {{(APB_DATA_BITS-8){1'b0}}, fill_byte_reg};

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

    assign hit = (s_payload.data_byte == fill_byte_reg);

    always_comb begin
        // Counter values with the current byte folded in.
        byte_total_next    = sat_inc(byte_total_reg);
        matched_total_next = hit ? sat_inc(matched_total_reg) : matched_total_reg;
        run_total_next     = (hit && !inside_run_reg) ? sat_inc(run_total_reg)
                                                      : run_total_reg;
        break_total_next   = (!hit && inside_run_reg) ? sat_inc(break_total_reg)
                                                      : break_total_reg;
        inside_run_next    = hit;
        seen_other_next    = seen_other_reg || !hit;

        likely = (matched_total_next >= (byte_total_next >> 1))
              && (break_total_next < cnt_t'(max_broken_runs_reg))
              && (matched_total_next > (run_total_next >> 1));

        result_next.likely_flooded   = likely;
        result_next.fully_flooded    = !seen_other_next;
        result_next.fill_count       = out_count_t'(matched_total_next);
        result_next.fill_run_count   = out_count_t'(run_total_next);
        result_next.broken_run_count = out_count_t'(break_total_next);

        m_valid_next = m_valid_reg && !m_ready;
        if (s_fire && s_payload.is_final) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_byte_reg       <= FILL_BYTE_RESET;
            max_broken_runs_reg <= MAX_BROKEN_RUNS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FILL_BYTE:       fill_byte_reg       <= pwdata[7:0];
                REG_MAX_BROKEN_RUNS: max_broken_runs_reg <= pwdata[7:0];
                default:             fill_byte_reg       <= fill_byte_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_total_reg    <= '0;
            matched_total_reg <= '0;
            run_total_reg     <= '0;
            break_total_reg   <= '0;
            inside_run_reg    <= 1'b0;
            seen_other_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                if (s_payload.is_final) begin
                    // The region is closed; start the next one from zero.
                    byte_total_reg    <= '0;
                    matched_total_reg <= '0;
                    run_total_reg     <= '0;
                    break_total_reg   <= '0;
                    inside_run_reg    <= 1'b0;
                    seen_other_reg    <= 1'b0;
                end else begin
                    byte_total_reg    <= byte_total_next;
                    matched_total_reg <= matched_total_next;
                    run_total_reg     <= run_total_next;
                    break_total_reg   <= break_total_next;
                    inside_run_reg    <= inside_run_next;
                    seen_other_reg    <= seen_other_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_payload.is_final) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== hdl/fpsc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the fill pattern span classifier, bound to fill_pattern_span_classifier_core.
// Depends on fpsc_pkg and fill_pattern_span_classifier_core.
module fpsc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input fpsc_pkg::in_beat_t                  s_payload,
    input logic                                m_valid,
    input logic                                m_ready,
    input fpsc_pkg::out_beat_t                 m_payload,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [fpsc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input logic [fpsc_pkg::APB_DATA_BITS-1:0]  pwdata,
    input logic [fpsc_pkg::APB_DATA_BITS-1:0]  prdata,
    input logic                                pready
);
    import fpsc_pkg::*;

    // A stalled result beat must hold its value.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // With the result register full and not drained, no input is taken.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");

    // A fully flooded region is one unbroken fill run.
    a_fully_one_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.fully_flooded |->
            m_payload.fill_run_count == out_count_t'(1)
            && m_payload.broken_run_count == '0)
        else $error("fully flooded region with broken or multiple runs");

    // A final byte accepted while the result slot is empty or being drained shows up next cycle.
    a_final_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.is_final |=> m_valid)
        else $error("final byte produced no result");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind fill_pattern_span_classifier_core fpsc_checker u_fpsc_checker (.*);
